### src/ess_pkg.sv
// ---------------------------------------------------------------------------
// Edge segment subdivider package
// Shared widths, beat layouts, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package ess_pkg;

	// Field widths of one beat.
	localparam int COORD_W = 32;
	localparam int RAD_W   = 24;
	// Lane width: a coordinate difference needs one bit more than a coordinate.
	localparam int LANE_W  = COORD_W + 1;
	// Magnitude of a difference and the number of restoring divider steps.
	localparam int MAG_W     = COORD_W;
	localparam int DIV_STEPS = MAG_W;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int DSQ_W     = 2 * RAD_W;
	localparam int LANES     = 4;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int IDX_W     = 8;

	localparam int MAX_SIDES_DEF = 64;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_SPLIT_MODE     = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SEGMENT_LENGTH = IDX_W'(1);
	localparam logic [RAD_W-1:0] SEG_LEN_RESET      = RAD_W'(256);

	// Operand selection for the shared squaring multiplier.
	localparam logic [1:0] MUL_DX  = 2'd0;
	localparam logic [1:0] MUL_DY  = 2'd1;
	localparam logic [1:0] MUL_DZ  = 2'd2;
	localparam logic [1:0] MUL_DIV = 2'd3;

	// One edge as it travels in tdata, start_x in the lowest bits.
	typedef struct packed {
		logic        [RAD_W-1:0]   end_radius;
		logic signed [COORD_W-1:0] end_z;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_x;
		logic        [RAD_W-1:0]   start_radius;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_x;
	} edge_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       search_init;
		logic       search_step;
		logic       div_init;
		logic       div_step;
		logic       emit_init;
		logic       seg_load;
		logic       pass_load;
	} ess_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_done;
		logic pass;
		logic seg_last;
		logic out_free;
	} ess_status_t;

endpackage

### src/edge_segment_subdivider.sv
// ---------------------------------------------------------------------------
// Edge segment subdivider
// Splits a 3D edge with end radii into equal segments by a side count found
// without a square root, or passes it through when one side suffices.
// ---------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_       in         one edge: start x/y/z/radius, end x/y/z/radius
//  m_       out        one segment; tuser marks a pass-through, tlast the end
//  cfg_     in         register index and write data, always ready
//
// An edge is squared, then its side count is searched (one candidate per
// cycle), then it gives either one output beat, or it passes through the
// serial divider and an emit set-up step before the segments leave at one a
// cycle while the sink keeps taking them. s_tready is high only between
// edges. The output register lets the last segment wait while the next edge
// is taken. Reset returns the registers to mode 0 and a segment length of 256.
// ---------------------------------------------------------------------------
module edge_segment_subdivider #(
	parameter int MAX_SIDES = ess_pkg::MAX_SIDES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// start_x, start_y, start_z, start_radius, end_x, end_y, end_z, end_radius
	input  logic [239:0]                s_tdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// seg_start_x/y/z, seg_start_radius, seg_end_x/y/z, seg_end_radius
	output logic [239:0]                m_tdata,
	// unchanged
	output logic                        m_tuser,
	output logic                        m_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ess_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ess_pkg::RAD_W-1:0]   cfg_data
);
	import ess_pkg::*;

	ess_cmd_t    cmd;
	ess_status_t status;
	edge_t       out_edge;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;
	assign m_tdata   = out_edge;

	ess_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ess_datapath #(
		.MAX_SIDES (MAX_SIDES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_edge       (edge_t'(s_tdata)),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.out_edge      (out_edge),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_unchanged (m_tuser),
		.out_last      (m_tlast)
	);

endmodule

### src/ess_ctrl.sv
// ---------------------------------------------------------------------------
// Edge segment subdivider controller
// Sequences one edge through squaring, side count search, division and
// segment emission, or through squaring, search and a pass-through beat.
// ---------------------------------------------------------------------------
module ess_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ess_pkg::ess_status_t status,
	output ess_pkg::ess_cmd_t    cmd
);
	import ess_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MUL    = 9'b000000010,
		ST_SINIT  = 9'b000000100,
		ST_SEARCH = 9'b000001000,
		ST_DECIDE = 9'b000010000,
		ST_DIV    = 9'b000100000,
		ST_EINIT  = 9'b001000000,
		ST_EMIT   = 9'b010000000,
		ST_PASS   = 9'b100000000
	} state_t;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cnt_d       = '0;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				// Four squares issued; the last one, of the divisor, is stored in the final step.
				cmd.mul_en  = (cnt_q != MUL_LAST);
				cmd.mul_sel = cnt_q[1:0];
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_SINIT;
				end
			end
			ST_SINIT: begin
				cmd.search_init = 1'b1;
				state_d         = ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (status.search_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.pass) begin
					state_d = ST_PASS;
				end else begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_EINIT;
				end
			end
			ST_EINIT: begin
				cmd.emit_init = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.seg_load = 1'b1;
					if (status.seg_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PASS: begin
				if (status.out_free) begin
					cmd.pass_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### src/ess_datapath.sv
// ---------------------------------------------------------------------------
// Edge segment subdivider datapath
// Holds the edge, squares and sums the differences, searches the side count,
// divides each difference by it and steps the interpolated points.
// ---------------------------------------------------------------------------
module ess_datapath #(
	parameter int MAX_SIDES = ess_pkg::MAX_SIDES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ess_pkg::edge_t                   in_edge,
	input  logic                             cfg_valid,
	input  logic [ess_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ess_pkg::RAD_W-1:0]        cfg_data,
	input  ess_pkg::ess_cmd_t                cmd,
	output ess_pkg::ess_status_t             status,
	output ess_pkg::edge_t                   out_edge,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             out_unchanged,
	output logic                             out_last
);
	import ess_pkg::*;

	localparam int KW    = $clog2(MAX_SIDES + 2);
	localparam int NW    = $clog2(MAX_SIDES + 1);
	localparam int ACC_W = DSQ_W + 2 * KW;
	localparam int CMP_W = (ACC_W > SQ_W) ? ACC_W : SQ_W;
	localparam logic [KW-1:0] K_LAST = KW'(MAX_SIDES + 1);
	localparam logic [KW-1:0] K_MAX  = KW'(MAX_SIDES);
	localparam logic [NW-1:0] N_MAX  = NW'(MAX_SIDES);

	// Configuration registers.
	logic             mode_q;
	logic [RAD_W-1:0] seglen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			seglen_q <= SEG_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPLIT_MODE:     mode_q   <= cfg_data[0];
				REG_SEGMENT_LENGTH: seglen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input beat split into four lanes: x, y, z and radius.
	logic signed [LANE_W-1:0] in_s [LANES];
	logic signed [LANE_W-1:0] in_e [LANES];

	always_comb begin
		in_s[0] = {in_edge.start_x[COORD_W-1], in_edge.start_x};
		in_s[1] = {in_edge.start_y[COORD_W-1], in_edge.start_y};
		in_s[2] = {in_edge.start_z[COORD_W-1], in_edge.start_z};
		in_s[3] = LANE_W'(in_edge.start_radius);
		in_e[0] = {in_edge.end_x[COORD_W-1], in_edge.end_x};
		in_e[1] = {in_edge.end_y[COORD_W-1], in_edge.end_y};
		in_e[2] = {in_edge.end_z[COORD_W-1], in_edge.end_z};
		in_e[3] = LANE_W'(in_edge.end_radius);
	end

	logic signed [LANE_W-1:0] st_q [LANES];
	logic signed [LANE_W-1:0] en_q [LANES];
	logic signed [LANE_W-1:0] df_q [LANES];
	logic        [MAG_W-1:0]  mag  [LANES];

	// Edge capture, with the per lane difference.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			for (int l = 0; l < LANES; l++) begin
				st_q[l] <= in_s[l];
				en_q[l] <= in_e[l];
				df_q[l] <= in_e[l] - in_s[l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag[l] = df_q[l][LANE_W-1] ? MAG_W'(-df_q[l]) : df_q[l][MAG_W-1:0];
		end
	end

	// Divisor: configured length or the larger radius.
	logic [RAD_W-1:0] dvs;
	always_comb begin
		if (mode_q) begin
			dvs = seglen_q;
		end else if (st_q[3][RAD_W-1:0] > en_q[3][RAD_W-1:0]) begin
			dvs = st_q[3][RAD_W-1:0];
		end else begin
			dvs = en_q[3][RAD_W-1:0];
		end
	end

	// Shared squaring multiplier, registered before the sum.
	logic [MAG_W-1:0] mop;
	logic [SQ_W-1:0]  prod_q;
	logic [1:0]       psel_q;
	logic             pvld_q;
	logic [SUM_W-1:0] sum_q;
	logic [DSQ_W-1:0] dsq_q;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_DX:  mop = mag[0];
			MUL_DY:  mop = mag[1];
			MUL_DZ:  mop = mag[2];
			MUL_DIV: mop = MAG_W'(dvs);
			default: mop = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= 1'b0;
		end else begin
			pvld_q <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mop * mop;
			psel_q <= cmd.mul_sel;
		end
		if (cmd.load_in) begin
			sum_q <= '0;
		end else if (pvld_q) begin
			if (psel_q == MUL_DIV) begin
				dsq_q <= prod_q[DSQ_W-1:0];
			end else begin
				sum_q <= sum_q + SUM_W'(prod_q);
			end
		end
	end

	// Side count search: k squared times the divisor squared, built by adds.
	logic [ACC_W-1:0] acc_q, stp_q;
	logic [KW-1:0]    ks_q, ns_q;
	logic             fits;
	logic [NW-1:0]    n_eff;

	assign fits = (sum_q[SUM_W-1:SQ_W] != '0) ||
		(CMP_W'(acc_q) <= CMP_W'(sum_q[SQ_W-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			acc_q <= ACC_W'(dsq_q);
			stp_q <= ACC_W'(dsq_q) + ACC_W'({dsq_q, 1'b0});
			ks_q  <= KW'(1);
			ns_q  <= '0;
		end else if (cmd.search_step) begin
			if (fits) begin
				ns_q <= ks_q;
			end
			acc_q <= acc_q + stp_q;
			stp_q <= stp_q + ACC_W'({dsq_q, 1'b0});
			ks_q  <= ks_q + 1'b1;
		end
	end

	assign n_eff = (ns_q > K_MAX) ? N_MAX : ns_q[NW-1:0];

	// Restoring divider, one quotient bit per cycle in each lane.
	logic [NW-1:0]            rem_q [LANES];
	logic [MAG_W-1:0]         quo_q [LANES];
	logic [NW:0]              rsh   [LANES];
	logic                     ge    [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rsh[l] = {rem_q[l], quo_q[l][MAG_W-1]};
			ge[l]  = (rsh[l] >= {1'b0, n_eff});
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (cmd.div_init) begin
				rem_q[l] <= '0;
				quo_q[l] <= mag[l];
			end else if (cmd.div_step) begin
				rem_q[l] <= ge[l] ? NW'(rsh[l] - {1'b0, n_eff}) : rsh[l][NW-1:0];
				quo_q[l] <= {quo_q[l][MAG_W-2:0], ge[l]};
			end
		end
	end

	// Point stepping: quotient and remainder of difference times k over n.
	logic signed [LANE_W-1:0] qd_q [LANES];
	logic        [NW-1:0]     rd_q [LANES];
	logic signed [LANE_W-1:0] q_q  [LANES];
	logic        [NW-1:0]     r_q  [LANES];
	logic        [NW:0]       r2   [LANES];
	logic                     cy   [LANES];
	logic signed [LANE_W-1:0] qn   [LANES];
	logic        [NW-1:0]     rn   [LANES];
	logic signed [LANE_W-1:0] pa   [LANES];
	logic signed [LANE_W-1:0] pb   [LANES];
	logic        [NW-1:0]     kseg_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			r2[l] = {1'b0, r_q[l]} + {1'b0, rd_q[l]};
			cy[l] = (r2[l] >= {1'b0, n_eff});
			rn[l] = cy[l] ? NW'(r2[l] - {1'b0, n_eff}) : r2[l][NW-1:0];
			qn[l] = q_q[l] + qd_q[l] + LANE_W'(cy[l]);
			pa[l] = st_q[l] + q_q[l];
			pb[l] = st_q[l] + qn[l];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_init) begin
			kseg_q <= '0;
			for (int l = 0; l < LANES; l++) begin
				q_q[l] <= '0;
				r_q[l] <= '0;
				// Floor division: a negative difference with a remainder rounds down.
				if (df_q[l][LANE_W-1] && (rem_q[l] != '0)) begin
					qd_q[l] <= -(LANE_W'(quo_q[l]) + LANE_W'(1));
					rd_q[l] <= n_eff - rem_q[l];
				end else if (df_q[l][LANE_W-1]) begin
					qd_q[l] <= -LANE_W'(quo_q[l]);
					rd_q[l] <= '0;
				end else begin
					qd_q[l] <= LANE_W'(quo_q[l]);
					rd_q[l] <= rem_q[l];
				end
			end
		end else if (cmd.seg_load) begin
			kseg_q <= kseg_q + 1'b1;
			for (int l = 0; l < LANES; l++) begin
				q_q[l] <= qn[l];
				r_q[l] <= rn[l];
			end
		end
	end

	// Output register: one beat held until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.seg_load || cmd.pass_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seg_load) begin
			out_edge.start_x      <= pa[0][COORD_W-1:0];
			out_edge.start_y      <= pa[1][COORD_W-1:0];
			out_edge.start_z      <= pa[2][COORD_W-1:0];
			out_edge.start_radius <= pa[3][RAD_W-1:0];
			out_edge.end_x        <= pb[0][COORD_W-1:0];
			out_edge.end_y        <= pb[1][COORD_W-1:0];
			out_edge.end_z        <= pb[2][COORD_W-1:0];
			out_edge.end_radius   <= pb[3][RAD_W-1:0];
			out_unchanged         <= 1'b0;
			out_last              <= status.seg_last;
		end else if (cmd.pass_load) begin
			out_edge.start_x      <= st_q[0][COORD_W-1:0];
			out_edge.start_y      <= st_q[1][COORD_W-1:0];
			out_edge.start_z      <= st_q[2][COORD_W-1:0];
			out_edge.start_radius <= st_q[3][RAD_W-1:0];
			out_edge.end_x        <= en_q[0][COORD_W-1:0];
			out_edge.end_y        <= en_q[1][COORD_W-1:0];
			out_edge.end_z        <= en_q[2][COORD_W-1:0];
			out_edge.end_radius   <= en_q[3][RAD_W-1:0];
			out_unchanged         <= 1'b1;
			out_last              <= 1'b1;
		end
	end

	// Status back to the controller.
	always_comb begin
		status.search_done = !fits || (ks_q == K_LAST);
		status.pass        = (n_eff <= NW'(1));
		status.seg_last    = (kseg_q == n_eff - 1'b1);
		status.out_free    = !out_valid || out_ready;
	end

endmodule

### src/ess_checker.sv
// ---------------------------------------------------------------------------
// Edge segment subdivider checker
// Port level properties of the subdivider, bound to the top level.
// ---------------------------------------------------------------------------
module ess_props (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tuser,
	input logic m_tlast
);

	// A beat that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// A pass-through edge is always a single, final beat.
	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("pass-through beat without tlast");

	// Once an edge is taken the block is busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

endmodule

bind edge_segment_subdivider ess_props u_ess_props (.*);
